@@ rtl/char_lcd_text_terminal_defines.svh @@
// Assertion macros for the character LCD text terminal checker.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef CHAR_LCD_TEXT_TERMINAL_DEFINES_SVH
`define CHAR_LCD_TEXT_TERMINAL_DEFINES_SVH

// Property must hold at every clock edge outside reset
`define CLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define CLT_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/clt_pkg.sv @@
// Shared types, display byte codes and glyph table for the LCD text terminal.
// No dependencies; used by the controller, the datapath and the top level.
package clt_pkg;

    localparam int CP_W   = 21;
    localparam int BYTE_W = 8;
    localparam int STEP_W = 4;

    // Display command bytes
    localparam logic [BYTE_W-1:0] LCD_PREFIX    = 8'hFE;
    localparam logic [BYTE_W-1:0] OP_GOTO       = 8'h47;
    localparam logic [BYTE_W-1:0] OP_CURSOR_OFF = 8'h54;
    localparam logic [BYTE_W-1:0] OP_WRAP_OFF   = 8'h44;
    localparam logic [BYTE_W-1:0] OP_SCROLL_ON  = 8'h51;
    localparam logic [BYTE_W-1:0] OP_SCROLL_OFF = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] GOTO_HOME     = 8'h01;

    // Code point classes
    localparam logic [CP_W-1:0] CP_NEWLINE     = 21'h00000A;
    localparam logic [CP_W-1:0] CP_PRINT_FIRST = 21'h000020;
    localparam logic [CP_W-1:0] CP_PRINT_LAST  = 21'h00007D;

    // Final byte position inside each fixed-length multi-byte run
    localparam logic [STEP_W-1:0] SETUP_LAST  = 4'd5;
    localparam logic [STEP_W-1:0] SCROLL_LAST = 4'd8;
    localparam logic [STEP_W-1:0] GOTO_LAST   = 4'd3;

    // Controller states; also name the byte run the datapath drives
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCROLL,
        ST_PAD,
        ST_GLYPH,
        ST_GOTO
    } state_t;

    // Byte runs that one input item causes
    typedef struct packed {
        logic is_begin;
        logic do_scroll;
        logic do_glyph;
        logic do_pad;
        logic do_goto;
    } plan_t;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                emit;
        state_t              seg;
        logic [STEP_W-1:0]   step;
        logic                last;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        plan_t now;
        plan_t held;
        logic  pad_last;
        logic  slot_free;
    } dp_stat_t;

    // Map a code point to its display glyph code
    function automatic logic [BYTE_W-1:0] glyph_code(input logic [CP_W-1:0] cp);
        logic [BYTE_W-1:0] code;
        case (cp)
            21'h00005C: code = 8'h8C;
            21'h00007E: code = 8'h8E;
            21'h00258F: code = 8'h10;
            21'h00258E: code = 8'h11;
            21'h00258D: code = 8'h12;
            21'h00258C: code = 8'h13;
            21'h00258B: code = 8'h14;
            21'h00266A: code = 8'h19;
            21'h002103: code = 8'h1A;
            21'h002109: code = 8'h1B;
            21'h0025BC: code = 8'h1C;
            21'h0025B6: code = 8'h1D;
            21'h0025C0: code = 8'h1E;
            21'h0025B2: code = 8'h1F;
            21'h0000A5: code = 8'h5C;
            21'h002192: code = 8'h7E;
            21'h002190: code = 8'h7F;
            21'h0000C4: code = 8'h80;
            21'h0000C2: code = 8'h82;
            21'h0000C5: code = 8'h82;
            21'h0000E1: code = 8'h83;
            21'h0000E5: code = 8'h84;
            21'h000395: code = 8'h85;
            21'h0000D6: code = 8'h86;
            21'h0000F8: code = 8'h89;
            21'h0000DC: code = 8'h8A;
            21'h002260: code = 8'h8D;
            21'h0000A7: code = 8'h8F;
            21'h0000C6: code = 8'h90;
            21'h0000E6: code = 8'h91;
            21'h0000A3: code = 8'h92;
            21'h0020A7: code = 8'h93;
            21'h0025CF: code = 8'h94;
            21'h0025CB: code = 8'h95;
            21'h0025C6: code = 8'h96;
            21'h0025C7: code = 8'h97;
            21'h0000A6: code = 8'h98;
            21'h0000E7: code = 8'h99;
            21'h0025FF: code = 8'h9A;
            21'h002264: code = 8'h9B;
            21'h002265: code = 8'h9C;
            21'h0023CE: code = 8'h9D;
            21'h002191: code = 8'h9E;
            21'h002193: code = 8'h9F;
            21'h0003B3: code = 8'hD8;
            21'h0000B0: code = 8'hDF;
            21'h0003B1: code = 8'hE0;
            21'h0000E4: code = 8'hE1;
            21'h0003B2: code = 8'hE2;
            21'h0003B5: code = 8'hE3;
            21'h0000B5: code = 8'hE4;
            21'h0003BC: code = 8'hE4;
            21'h0003C3: code = 8'hE5;
            21'h0003C1: code = 8'hE6;
            21'h0000A2: code = 8'hEC;
            21'h0000F1: code = 8'hEE;
            21'h0000F6: code = 8'hEF;
            21'h0003B8: code = 8'hF2;
            21'h0003A9: code = 8'hF4;
            21'h0000FC: code = 8'hF5;
            21'h0003A3: code = 8'hF6;
            21'h0003C0: code = 8'hF7;
            21'h0000F7: code = 8'hFD;
            // User glyph slots
            21'h0000E8: code = 8'h00;
            21'h0000E9: code = 8'h01;
            21'h0000EB: code = 8'h02;
            21'h0000F4: code = 8'h03;
            21'h0003B4: code = 8'h04;
            21'h0003BB: code = 8'h05;
            21'h0000A9: code = 8'h06;
            21'h0020AC: code = 8'h07;
            default:
            begin
                if (cp >= CP_PRINT_FIRST && cp <= CP_PRINT_LAST)
                    code = cp[BYTE_W-1:0];
                else
                    code = CHAR_SPACE;
            end
        endcase
        return code;
    endfunction

endpackage

@@ rtl/clt_ctrl.sv @@
// Sequencing state machine of the LCD text terminal: picks the byte runs for
// an item and steps through them. Depends on clt_pkg.
module clt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  clt_pkg::dp_stat_t   stat,
    output clt_pkg::ctl_cmd_t   cmd
);
    import clt_pkg::*;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // State and byte position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.seg    = state_reg;
        cmd.step   = step_reg;
        in_ready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load  = 1'b1;
                    step_next = '0;
                    if (stat.now.is_begin)
                        state_next = ST_SETUP;
                    else if (stat.now.do_scroll)
                        state_next = ST_SCROLL;
                    else if (stat.now.do_glyph)
                        state_next = ST_GLYPH;
                    else if (stat.now.do_pad)
                        state_next = ST_PAD;
                    else if (stat.now.do_goto)
                        state_next = ST_GOTO;
                end
            end
            ST_SETUP:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (step_reg == SETUP_LAST)
                    begin
                        step_next  = '0;
                        state_next = ST_GOTO;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
            end
            ST_SCROLL:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (step_reg == SCROLL_LAST)
                    begin
                        step_next  = '0;
                        state_next = stat.held.do_glyph ? ST_GLYPH : ST_PAD;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
            end
            ST_PAD:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.pad_last)
                    begin
                        cmd.last   = !stat.held.do_goto;
                        step_next  = '0;
                        state_next = stat.held.do_goto ? ST_GOTO : ST_IDLE;
                    end
                end
            end
            ST_GLYPH:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_GOTO:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (step_reg == GOTO_LAST)
                    begin
                        cmd.last   = 1'b1;
                        step_next  = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        step_next = step_reg + 4'd1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/clt_datapath.sv @@
// Cursor state, item planning, glyph lookup and output byte register of the
// LCD text terminal. Depends on clt_pkg.
module clt_datapath #(
    parameter int TEXT_WIDTH  = 20,
    parameter int TEXT_HEIGHT = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  clt_pkg::ctl_cmd_t            cmd,
    output clt_pkg::dp_stat_t            stat,
    input  logic                         in_command,
    input  logic [clt_pkg::CP_W-1:0]     in_code_point,
    input  logic                         cfg_we,
    input  logic                         cfg_wdata,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [clt_pkg::BYTE_W-1:0]   out_byte,
    output logic                         out_last
);
    import clt_pkg::*;

    localparam int COL_W = $clog2(TEXT_WIDTH + 1);
    localparam int ROW_W = $clog2(TEXT_HEIGHT + 1);

    localparam logic [COL_W-1:0]  COL_MAX    = COL_W'(TEXT_WIDTH);
    localparam logic [ROW_W-1:0]  ROW_MAX    = ROW_W'(TEXT_HEIGHT);
    localparam logic [ROW_W-1:0]  ROW_BOTTOM = ROW_W'(TEXT_HEIGHT - 1);
    localparam logic [ROW_W:0]    ROW_LIMIT  = (ROW_W+1)'(TEXT_HEIGHT);
    localparam logic [BYTE_W-1:0] EDGE_COL   = BYTE_W'(TEXT_WIDTH + 1);
    localparam logic [BYTE_W-1:0] EDGE_ROW   = BYTE_W'(TEXT_HEIGHT);

    logic                 log_mode_reg;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 pend_reg, pend_next;

    plan_t                plan_now, plan_reg;
    logic [COL_W-1:0]     pad_cnt_reg, pad_now;
    logic [BYTE_W-1:0]    glyph_reg;
    logic [BYTE_W-1:0]    goto_row_reg, goto_row_now;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg, byte_sel;
    logic                 out_last_reg;

    logic                 is_newline;
    logic                 in_window;
    logic                 scroll_now;
    logic [ROW_W:0]       row_inc;
    logic                 wrap;
    logic [ROW_W-1:0]     row_nl;

    // Plan the byte runs and the cursor update for the offered item
    always_comb
    begin
        is_newline   = (in_code_point == CP_NEWLINE);
        in_window    = (row_reg < ROW_MAX) && (col_reg < COL_MAX);
        row_inc      = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1);
        wrap         = log_mode_reg && (row_inc >= ROW_LIMIT);
        if (wrap)
            row_nl = ROW_BOTTOM;
        else if (row_inc > ROW_LIMIT)
            row_nl = ROW_MAX;
        else
            row_nl = row_inc[ROW_W-1:0];
        pad_now      = (row_reg < ROW_MAX) ? (COL_MAX - col_reg) : '0;
        scroll_now   = 1'b0;
        plan_now     = '0;
        goto_row_now = GOTO_HOME;
        col_next     = col_reg;
        row_next     = row_reg;
        pend_next    = pend_reg;
        if (in_command)
        begin
            plan_now.is_begin = 1'b1;
            plan_now.do_goto  = 1'b1;
            col_next          = '0;
            row_next          = '0;
        end
        else if (is_newline)
        begin
            scroll_now        = log_mode_reg && pend_reg && (pad_now != '0);
            plan_now.do_scroll = scroll_now;
            plan_now.do_pad   = (pad_now != '0);
            plan_now.do_goto  = (row_nl < ROW_MAX);
            goto_row_now      = BYTE_W'(row_nl) + 8'd1;
            col_next          = '0;
            row_next          = row_nl;
            if (wrap)
                pend_next = 1'b1;
            else if (scroll_now)
                pend_next = 1'b0;
        end
        else if (in_window)
        begin
            scroll_now         = log_mode_reg && pend_reg;
            plan_now.do_scroll = scroll_now;
            plan_now.do_glyph  = 1'b1;
            col_next           = (scroll_now ? '0 : col_reg) + COL_W'(1);
            row_next           = scroll_now ? ROW_BOTTOM : row_reg;
            pend_next          = scroll_now ? 1'b0 : pend_reg;
        end
    end

    // Configuration and cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_mode_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= 1'b0;
            plan_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                log_mode_reg <= cfg_wdata;
            if (cmd.load)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                pend_reg <= pend_next;
                plan_reg <= plan_now;
            end
        end
    end

    // Hold glyph, goto row and pad count for the item in progress
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            glyph_reg    <= glyph_code(in_code_point);
            goto_row_reg <= goto_row_now;
            pad_cnt_reg  <= pad_now;
        end
        else if (cmd.emit && cmd.seg == ST_PAD)
            pad_cnt_reg <= pad_cnt_reg - COL_W'(1);
    end

    // Select the byte for the current run and position
    always_comb
    begin
        byte_sel = CHAR_SPACE;
        case (cmd.seg)
            ST_SETUP:
            begin
                case (cmd.step)
                    4'd1:    byte_sel = OP_CURSOR_OFF;
                    4'd3:    byte_sel = OP_WRAP_OFF;
                    4'd5:    byte_sel = log_mode_reg ? OP_SCROLL_ON : OP_SCROLL_OFF;
                    default: byte_sel = LCD_PREFIX;
                endcase
            end
            ST_SCROLL:
            begin
                case (cmd.step)
                    4'd0:    byte_sel = LCD_PREFIX;
                    4'd1:    byte_sel = OP_GOTO;
                    4'd2:    byte_sel = EDGE_COL;
                    4'd3:    byte_sel = EDGE_ROW;
                    4'd4:    byte_sel = CHAR_SPACE;
                    4'd5:    byte_sel = LCD_PREFIX;
                    4'd6:    byte_sel = OP_GOTO;
                    4'd7:    byte_sel = GOTO_HOME;
                    default: byte_sel = EDGE_ROW;
                endcase
            end
            ST_GLYPH:
            begin
                byte_sel = glyph_reg;
            end
            ST_GOTO:
            begin
                case (cmd.step)
                    4'd0:    byte_sel = LCD_PREFIX;
                    4'd1:    byte_sel = OP_GOTO;
                    4'd2:    byte_sel = GOTO_HOME;
                    default: byte_sel = goto_row_reg;
                endcase
            end
            default:
            begin
                byte_sel = CHAR_SPACE;
            end
        endcase
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= byte_sel;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    // Status back to the controller
    assign stat.now       = plan_now;
    assign stat.held      = plan_reg;
    assign stat.pad_last  = (pad_cnt_reg == COL_W'(1));
    assign stat.slot_free = !out_valid_reg || out_ready;

endmodule

@@ rtl/char_lcd_text_terminal.sv @@
// Top level of the character LCD text terminal: stream ports, controller
// and datapath. Depends on clt_pkg, clt_ctrl and clt_datapath.
//
// Channel   Direction  Transaction
// s_axis    in         tdata = code_point, tuser = command (1 = begin page)
// m_axis    out        tdata = out_byte, tlast = final byte of the item
// cfg       in         cfg_we / cfg_wdata write log_mode
//
// An item is taken while idle, then one output byte leaves per cycle: a
// character its glyph (after any pending scroll run), begin page a setup
// run and a goto, a newline its pad spaces (after any due scroll run) and
// a goto if one follows; other items send none. A single output register
// sets the byte rate; a stall on m_axis holds the sequencer in place.
// Reset clears the cursor, the scroll flag and log_mode.
module char_lcd_text_terminal #(
    parameter int TEXT_WIDTH  = 20,
    parameter int TEXT_HEIGHT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [20:0] code_point, [23:21] zero
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import clt_pkg::*;

    ctl_cmd_t cmd;
    dp_stat_t stat;

    clt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clt_datapath #(
        .TEXT_WIDTH  (TEXT_WIDTH),
        .TEXT_HEIGHT (TEXT_HEIGHT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_command    (s_axis_tuser),
        .in_code_point (s_axis_tdata[CP_W-1:0]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .out_last      (m_axis_tlast)
    );

endmodule

@@ rtl/clt_checker.sv @@
// Port-level checks for the LCD text terminal, bound to the top level.
// Depends on char_lcd_text_terminal_defines.svh.
`include "char_lcd_text_terminal_defines.svh"

module clt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Hold a stalled output transaction
    `CLT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

    // A begin page always produces bytes, so input closes after it
    `CLT_ASSERT(a_begin_busy, s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready, "input open right after begin page")

    // Bytes of one item follow each other without a gap
    `CLT_ASSERT(a_no_gap, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid, "gap inside an item's bytes")

    // No new item while the current one still has bytes to send
    `CLT_ASSERT_NEVER(a_item_open, m_axis_tvalid && !m_axis_tlast && s_axis_tready, "input open mid-item")

endmodule

bind char_lcd_text_terminal clt_checker u_clt_checker (.*);
